FILE: rtl/pls_pkg.sv
// Shared types and codes for the positional list store.
// Depends on nothing; imported by the cell, the controller and the top level.
package pls_pkg;

  // Action codes carried by the action field of an input word
  typedef enum logic [2:0] {
    ACT_APPEND       = 3'd0,
    ACT_PREPEND      = 3'd1,
    ACT_INSERT_AT    = 3'd2,
    ACT_REMOVE_FIRST = 3'd3,
    ACT_REMOVE_LAST  = 3'd4,
    ACT_REMOVE_AT    = 3'd5,
    ACT_DUMP         = 3'd6
  } action_e;

  // Status codes of a result word
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // A dump emits at most this many words
  localparam int unsigned MaxResults = 32;

  // Shift operation applied to the whole chain
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_INSERT,
    SH_REMOVE,
    SH_ROTATE
  } shift_e;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_DUMPING
  } state_e;

  // Command broadcast to every cell
  typedef struct packed {
    shift_e             op;
    logic [5:0]         slot;  // target slot of an insert or a removal
    logic [5:0]         tail;  // last occupied slot, for rotation
    logic signed [31:0] value; // value written by an insert
  } cell_cmd_t;

endpackage

FILE: rtl/pls_cell.sv
// One storage cell of the list chain: holds one entry and takes its
// neighbour's value on a shift. Depends on pls_pkg.
module pls_cell
  import pls_pkg::*;
#(
  parameter int unsigned Index = 0
) (
  input  logic               clk_i,
  input  cell_cmd_t          cmd_i,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  input  logic signed [31:0] head_i,
  output logic signed [31:0] data_o
);

  localparam logic [5:0] Slot = 6'(Index);

  logic signed [31:0] data_q;
  logic signed [31:0] data_d;

  // Pick the next entry from the broadcast command
  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      SH_INSERT: begin
        if (Slot == cmd_i.slot) begin
          data_d = cmd_i.value;
        end else if (Slot > cmd_i.slot) begin
          data_d = left_i;
        end
      end
      SH_REMOVE: begin
        if (Slot >= cmd_i.slot) begin
          data_d = right_i;
        end
      end
      SH_ROTATE: begin
        if (Slot == cmd_i.tail) begin
          data_d = head_i;
        end else if (Slot < cmd_i.tail) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // Entry storage has no reset: unwritten slots are never read
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/pls_ctrl.sv
// Controller of the list store: decodes actions, keeps the count, drives the
// cell chain and the output register. Depends on pls_pkg.
module pls_ctrl
  import pls_pkg::*;
#(
  parameter int unsigned Capacity = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic [5:0]         position_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] head_i,
  output cell_cmd_t          cmd_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] item_value_o,
  output logic [5:0]         item_position_o,
  output logic [5:0]         entry_count_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] Full = CntW'(Capacity);
  // Dump limit clipped to the capacity so it always fits the index width
  localparam int unsigned DumpLim = (Capacity < MaxResults) ? Capacity : MaxResults;
  localparam logic [CntW-1:0] DumpMax = CntW'(DumpLim);

  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] value_q, value_d;
  logic [5:0]         pos_q, pos_d;
  logic [5:0]         cnt_out_q, cnt_out_d;
  logic [1:0]         status_q, status_d;
  logic               last_q, last_d;

  logic       out_free;
  logic       accept;
  logic       pos_zero;
  logic       ins_ok;
  logic       rem_ok;
  logic       full;
  logic       emit;
  logic [5:0] tail;
  action_e    action;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept = in_valid_i && !in_stall_o;
  assign action = action_e'(action_i);
  assign full = (count_q == Full);
  assign pos_zero = (position_i == 6'd0);
  assign ins_ok = !pos_zero && ({2'b00, position_i} <= (8'(count_q) + 8'd1));
  assign rem_ok = !pos_zero && ({2'b00, position_i} <= 8'(count_q));
  assign tail = 6'(count_q - CntW'(1));
  assign emit = (idx_q < DumpMax);

  // Decode the action, step the dump, and load the output register
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    value_d     = value_q;
    pos_d       = pos_q;
    cnt_out_d   = cnt_out_q;
    status_d    = status_q;
    last_d      = last_q;
    cmd_o.op    = SH_HOLD;
    cmd_o.slot  = 6'd0;
    cmd_o.tail  = tail;
    cmd_o.value = value_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          value_d     = '0;
          pos_d       = 6'd0;
          status_d    = ST_DONE;
          last_d      = 1'b1;
          case (action)
            ACT_APPEND, ACT_PREPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                cmd_o.op   = SH_INSERT;
                cmd_o.slot = (action == ACT_APPEND) ? 6'(count_q) : 6'd0;
                count_d    = count_q + CntW'(1);
              end
            end
            ACT_INSERT_AT: begin
              if (!ins_ok) begin
                status_d = ST_IGNORED;
              end else if (full) begin
                status_d = ST_FULL;
              end else begin
                cmd_o.op   = SH_INSERT;
                cmd_o.slot = position_i - 6'd1;
                count_d    = count_q + CntW'(1);
              end
            end
            ACT_REMOVE_FIRST, ACT_REMOVE_LAST: begin
              if (count_q == '0) begin
                status_d = ST_IGNORED;
              end else begin
                cmd_o.op   = SH_REMOVE;
                cmd_o.slot = (action == ACT_REMOVE_LAST) ? tail : 6'd0;
                count_d    = count_q - CntW'(1);
              end
            end
            ACT_REMOVE_AT: begin
              if (!rem_ok) begin
                status_d = ST_IGNORED;
              end else begin
                cmd_o.op   = SH_REMOVE;
                cmd_o.slot = position_i - 6'd1;
                count_d    = count_q - CntW'(1);
              end
            end
            ACT_DUMP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                // nothing emitted yet: the dump loop produces the words
                out_valid_d = 1'b0;
                idx_d       = '0;
                state_d     = ST_DUMPING;
              end
            end
            default: status_d = ST_IGNORED;
          endcase
          cnt_out_d = 6'(count_d);
        end
      end
      ST_DUMPING: begin
        // Rotate the chain once per step; emit the head while in range
        if (!emit || out_free) begin
          cmd_o.op = SH_ROTATE;
          if (emit) begin
            out_valid_d = 1'b1;
            value_d     = head_i;
            pos_d       = 6'(idx_q + CntW'(1));
            cnt_out_d   = 6'(count_q);
            status_d    = ST_DONE;
            last_d      = (idx_q == count_q - CntW'(1)) ||
                          (idx_q == DumpMax - CntW'(1));
          end
          idx_d = idx_q + CntW'(1);
          if (idx_q == count_q - CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the state and the control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    pos_q     <= pos_d;
    cnt_out_q <= cnt_out_d;
    status_q  <= status_d;
    last_q    <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign item_value_o    = value_q;
  assign item_position_o = pos_q;
  assign entry_count_o   = cnt_out_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

endmodule

FILE: rtl/positional_list_store.sv
// Top level of the positional list store: a controller and a chain of
// entry cells. Depends on pls_pkg, pls_cell and pls_ctrl.
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o | action_i, position_i, value_i
//  out     | out_valid_o/out_stall_i | item_value_o, item_position_o,
//          |                         | entry_count_o, status_o, last_o
//
// Inserts and removals shift the whole cell chain together: one word per cycle
// while results are taken. A dump accepts the action, then rotates the chain one
// step per cycle, the first 32 steps each giving a word when the output is free.
// Reset clears the count and the controller; cell contents are left as they are.
// A stall on the output holds the result register and, in turn, the input.
module positional_list_store
  import pls_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic [5:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] item_value_o,
  output logic [5:0]         item_position_o,
  output logic [5:0]         entry_count_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  cell_cmd_t          cmd;
  logic signed [31:0] data [CAPACITY];

  pls_ctrl #(
    .Capacity (CAPACITY)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .head_i          (data[0]),
    .cmd_o           (cmd),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .item_value_o    (item_value_o),
    .item_position_o (item_position_o),
    .entry_count_o   (entry_count_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  // Build the chain: each cell sees both neighbours and the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left;
    logic signed [31:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_inner_r
      assign right = data[i+1];
    end
    pls_cell #(
      .Index (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .head_i  (data[0]),
      .data_o  (data[i])
    );
  end

endmodule
